### rtl/core/ssit_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ssit_pkg
// Shared types and constants for the tolerant sorted set block.
// ----------------------------------------------------------------------------
package ssit_pkg;

   // fixed field widths
   localparam int VALUE_W = 32;
   localparam int TOL_W   = 31;
   localparam int OP_W    = 2;
   localparam int IDX_W   = 6;
   localparam int POS_W   = 7;

   // defaults
   localparam int             CAPACITY_DEF = 64;
   localparam logic [TOL_W-1:0] TOL_RESET  = 31'd66;

   // operation codes
   typedef enum logic [OP_W-1:0] {
      OP_INSERT = 2'd0,
      OP_READ   = 2'd1,
      OP_CLEAR  = 2'd2,
      OP_NOP    = 2'd3
   } op_type;

   // sequencer states
   typedef enum logic [1:0] {
      ST_IDLE,
      ST_EVAL,
      ST_FINISH
   } state_type;

   // broadcast from the sequencer to every cell
   typedef struct packed {
      logic                      eval;
      logic                      shift;
      logic signed [VALUE_W-1:0] value;
      logic [TOL_W-1:0]          tol;
      logic [IDX_W-1:0]          read_index;
   } cell_ctl_type;

endpackage
`default_nettype wire

### rtl/core/ssit_cell.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ssit_cell
// One slot of the sorted row: holds an entry, compares it to the word under
// test and shifts up from its lower neighbor on an insert.
// ----------------------------------------------------------------------------
module ssit_cell #(
   parameter int N   = ssit_pkg::CAPACITY_DEF,
   parameter int IDX = 0
) (
   input  wire logic                               clock,
   input  wire ssit_pkg::cell_ctl_type             ctl,
   input  wire logic [$clog2(N+1)-1:0]             count,
   input  wire logic signed [ssit_pkg::VALUE_W-1:0] prev_entry,
   input  wire logic                               prev_below,
   output logic signed [ssit_pkg::VALUE_W-1:0]     entry,
   output logic                                    below,
   output logic                                    near,
   output logic                                    far_lo,
   output logic signed [ssit_pkg::VALUE_W-1:0]     rd_value
);

   localparam int CW = $clog2(N+1);

   logic signed [ssit_pkg::VALUE_W-1:0] entry_ff, entry_in;
   logic below_ff, below_in;
   logic near_ff, near_in;
   logic far_ff, far_in;
   logic valid;
   logic signed [ssit_pkg::VALUE_W:0]   diff;
   logic signed [ssit_pkg::VALUE_W+1:0] diff_x, tol_x, ntol_x;

   assign valid = (CW'(IDX) < count);

   // exact distance to the word under test
   always_comb begin
      diff   = {entry_ff[ssit_pkg::VALUE_W-1], entry_ff}
             - {ctl.value[ssit_pkg::VALUE_W-1], ctl.value};
      diff_x = {diff[ssit_pkg::VALUE_W], diff};
      tol_x  = {3'b000, ctl.tol};
      ntol_x = -tol_x;
   end

   // compare flags, captured in the evaluate cycle
   always_comb begin
      below_in = below_ff;
      near_in  = near_ff;
      far_in   = far_ff;
      if (ctl.eval) begin
         below_in = valid & diff[ssit_pkg::VALUE_W];
         near_in  = valid & (diff_x <= tol_x) & (diff_x >= ntol_x);
         far_in   = valid & (diff_x < ntol_x);
      end
   end

   // shift up past the insertion point, take the new word at it
   always_comb begin
      entry_in = entry_ff;
      if (ctl.shift) begin
         if (!prev_below) begin
            entry_in = prev_entry;
         end else if (!below_ff) begin
            entry_in = ctl.value;
         end
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
      below_ff <= below_in;
      near_ff  <= near_in;
      far_ff   <= far_in;
   end

   assign entry    = entry_ff;
   assign below    = below_ff;
   assign near     = near_ff;
   assign far_lo   = far_ff;
   assign rd_value = (valid && (int'(ctl.read_index) == IDX)) ? entry_ff : '0;

endmodule
`default_nettype wire

### rtl/core/ssit_therm_enc.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ssit_therm_enc
// Thermometer to binary: number of leading ones of a prefix-set flag vector,
// found by a bitwise binary search.
// ----------------------------------------------------------------------------
module ssit_therm_enc #(
   parameter int N = ssit_pkg::CAPACITY_DEF
) (
   input  wire logic [N-1:0]             therm,
   output logic      [$clog2(N+1)-1:0]   ones
);

   localparam int CW = $clog2(N+1);
   localparam int IW = (N > 1) ? $clog2(N) : 1;

   // greedy search from the top bit: keep a bit when flag[cand-1] is set
   always_comb begin
      logic [CW-1:0] lo;
      logic [CW-1:0] cand;
      logic [CW-1:0] cand_m1;
      lo = '0;
      for (int b = CW-1; b >= 0; b--) begin
         cand    = lo | (CW'(1) << b);
         cand_m1 = cand - CW'(1);
         if (({1'b0, cand} <= (CW+1)'(N)) && therm[cand_m1[IW-1:0]]) begin
            lo = cand;
         end
      end
      ones = lo;
   end

endmodule
`default_nettype wire

### rtl/core/sorted_set_insert_with_tolerance.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sorted_set_insert_with_tolerance
// Ascending set of signed Q16.16 words held in a row of cells; inserts drop
// near duplicates, reads return an entry, clear empties the set.
// ----------------------------------------------------------------------------
// Each item passes a compare cycle in the cell row and then an update cycle
//   where the row shifts and the result word is registered; an output stall
//   holds the update cycle. A new request is taken as the previous one retires.
// Reset: entry count 0, tolerance 66, sequencer idle. Cell contents stay
//   undefined; no clearing pass is run.
module sorted_set_insert_with_tolerance #(
   parameter int CAPACITY = ssit_pkg::CAPACITY_DEF
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   // request channel
   input  wire logic                                req_valid,
   output logic                                     req_stall,
   input  wire logic [ssit_pkg::OP_W-1:0]           req_operation,
   input  wire logic signed [ssit_pkg::VALUE_W-1:0] req_value,
   input  wire logic [ssit_pkg::IDX_W-1:0]          req_read_index,
   // response channel
   output logic                                     rsp_valid,
   input  wire logic                                rsp_stall,
   output logic [ssit_pkg::POS_W-1:0]               rsp_position,
   output logic                                     rsp_inserted,
   output logic                                     rsp_duplicate,
   output logic                                     rsp_full_res,
   output logic signed [ssit_pkg::VALUE_W-1:0]      rsp_read_value,
   output logic [ssit_pkg::POS_W-1:0]               rsp_entry_count,
   // tolerance register
   input  wire logic                                csr_wr_en,
   input  wire logic [ssit_pkg::TOL_W-1:0]          csr_wr_data
);

   localparam int CW = $clog2(CAPACITY+1);

   ssit_pkg::state_type state_ff, state_in;

   logic [ssit_pkg::TOL_W-1:0]          tol_ff;
   logic [CW-1:0]                       count_ff, count_in;
   ssit_pkg::op_type                    op_ff;
   logic signed [ssit_pkg::VALUE_W-1:0] value_ff;
   logic [ssit_pkg::IDX_W-1:0]          idx_ff;

   logic                                rsp_valid_ff, rsp_valid_in;
   logic [ssit_pkg::POS_W-1:0]          pos_ff, pos_in;
   logic                                ins_ff, ins_in;
   logic                                dup_ff, dup_in;
   logic                                full_ff, full_in;
   logic signed [ssit_pkg::VALUE_W-1:0] rval_ff, rval_in;
   logic [ssit_pkg::POS_W-1:0]          cnt_out_ff, cnt_out_in;

   logic req_take, finish_go, found, store_full, do_shift;
   ssit_pkg::cell_ctl_type ctl;

   logic signed [ssit_pkg::VALUE_W-1:0] entry_vec [CAPACITY];
   logic signed [ssit_pkg::VALUE_W-1:0] rd_vec    [CAPACITY];
   logic [CAPACITY-1:0]                 below_vec, near_vec, far_vec;
   logic [CW-1:0]                       below_cnt, far_cnt;
   logic signed [ssit_pkg::VALUE_W-1:0] rd_or;

   // handshake
   assign finish_go = (state_ff == ssit_pkg::ST_FINISH) && (!rsp_valid_ff || !rsp_stall);
   assign req_stall = !((state_ff == ssit_pkg::ST_IDLE) || finish_go);
   assign req_take  = req_valid && !req_stall;

   // sequencer
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ssit_pkg::ST_IDLE: begin
            if (req_take) begin
               state_in = ssit_pkg::ST_EVAL;
            end
         end
         ssit_pkg::ST_EVAL: begin
            state_in = ssit_pkg::ST_FINISH;
         end
         ssit_pkg::ST_FINISH: begin
            if (finish_go) begin
               state_in = req_take ? ssit_pkg::ST_EVAL : ssit_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = ssit_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ssit_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // tolerance register
   always_ff @(posedge clock) begin
      if (reset) begin
         tol_ff <= ssit_pkg::TOL_RESET;
      end else if (csr_wr_en) begin
         tol_ff <= csr_wr_data;
      end
   end

   // request holding register
   always_ff @(posedge clock) begin
      if (req_take) begin
         op_ff    <= ssit_pkg::op_type'(req_operation);
         value_ff <= req_value;
         idx_ff   <= req_read_index;
      end
   end

   // cell row
   assign found      = |near_vec;
   assign store_full = (count_ff == CW'(CAPACITY));
   assign do_shift   = finish_go && (op_ff == ssit_pkg::OP_INSERT) && !found && !store_full;

   always_comb begin
      ctl.eval       = (state_ff == ssit_pkg::ST_EVAL);
      ctl.shift      = do_shift;
      ctl.value      = value_ff;
      ctl.tol        = tol_ff;
      ctl.read_index = idx_ff;
   end

   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      logic signed [ssit_pkg::VALUE_W-1:0] prev_entry;
      logic                                prev_below;
      if (i == 0) begin : g_head
         assign prev_entry = value_ff;
         assign prev_below = 1'b1;
      end else begin : g_link
         assign prev_entry = entry_vec[i-1];
         assign prev_below = below_vec[i-1];
      end
      ssit_cell #(
         .N   (CAPACITY),
         .IDX (i)
      ) u_cell (
         .clock      (clock),
         .ctl        (ctl),
         .count      (count_ff),
         .prev_entry (prev_entry),
         .prev_below (prev_below),
         .entry      (entry_vec[i]),
         .below      (below_vec[i]),
         .near       (near_vec[i]),
         .far_lo     (far_vec[i]),
         .rd_value   (rd_vec[i])
      );
   end

   // sorted positions from the flag prefixes
   ssit_therm_enc #(.N(CAPACITY)) u_below_enc (
      .therm (below_vec),
      .ones  (below_cnt)
   );

   ssit_therm_enc #(.N(CAPACITY)) u_far_enc (
      .therm (far_vec),
      .ones  (far_cnt)
   );

   // read select: at most one cell drives a nonzero word
   always_comb begin
      rd_or = '0;
      for (int i = 0; i < CAPACITY; i++) begin
         rd_or = rd_or | rd_vec[i];
      end
   end

   // result word and count update
   always_comb begin
      count_in = count_ff;
      pos_in   = '0;
      ins_in   = 1'b0;
      dup_in   = 1'b0;
      full_in  = 1'b0;
      rval_in  = '0;
      case (op_ff)
         ssit_pkg::OP_INSERT: begin
            if (found) begin
               dup_in = 1'b1;
               pos_in = ssit_pkg::POS_W'(far_cnt);
            end else begin
               pos_in = ssit_pkg::POS_W'(below_cnt);
               if (store_full) begin
                  full_in = 1'b1;
               end else begin
                  ins_in   = 1'b1;
                  count_in = count_ff + CW'(1);
               end
            end
         end
         ssit_pkg::OP_READ: begin
            pos_in  = ssit_pkg::POS_W'(idx_ff);
            rval_in = rd_or;
         end
         ssit_pkg::OP_CLEAR: begin
            count_in = '0;
         end
         default: begin
            count_in = count_ff;
         end
      endcase
      cnt_out_in = ssit_pkg::POS_W'(count_in);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else if (finish_go) begin
         count_ff <= count_in;
      end
   end

   // output register
   assign rsp_valid_in = finish_go || (rsp_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (finish_go) begin
         pos_ff     <= pos_in;
         ins_ff     <= ins_in;
         dup_ff     <= dup_in;
         full_ff    <= full_in;
         rval_ff    <= rval_in;
         cnt_out_ff <= cnt_out_in;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_position    = pos_ff;
   assign rsp_inserted    = ins_ff;
   assign rsp_duplicate   = dup_ff;
   assign rsp_full_res    = full_ff;
   assign rsp_read_value  = rval_ff;
   assign rsp_entry_count = cnt_out_ff;

`ifndef SYNTH
   // count never passes the capacity
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(CAPACITY))
      else $error("entry count above capacity");

   // an item outcome is at most one of inserted, duplicate, full
   a_outcome_excl: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> $onehot0({ins_ff, dup_ff, full_ff}))
      else $error("conflicting insert outcome flags");

   // a row shift grows the set by exactly one
   a_shift_count: assert property (@(posedge clock) disable iff (reset)
      do_shift |=> (count_ff == $past(count_ff) + CW'(1)))
      else $error("shift without count increment");

   // compare cycle always leads to the update cycle
   a_eval_finish: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ssit_pkg::ST_EVAL) |=> (state_ff == ssit_pkg::ST_FINISH))
      else $error("evaluate not followed by finish");

   // a request is taken only when idle or while retiring the previous one
   a_take_state: assert property (@(posedge clock) disable iff (reset)
      req_take |-> ((state_ff == ssit_pkg::ST_IDLE) || finish_go))
      else $error("request taken mid item");
`endif

endmodule
`default_nettype wire
